// ===== design/fastcgi_script_filename_extractor_macros.svh =====
// assertion macros used by the checker file
`ifndef FASTCGI_SCRIPT_FILENAME_EXTRACTOR_MACROS_SVH
`define FASTCGI_SCRIPT_FILENAME_EXTRACTOR_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define FSFE_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked assertion that also holds during reset
`define FSFE_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== design/fsfe_pkg.sv =====
`default_nettype none

package fsfe_pkg;

  // pair buffer capacity and the pair offset counter it sets
  localparam int PAIR_CAPACITY = 4096;
  localparam int POFF_W        = $clog2(PAIR_CAPACITY);
  localparam logic [POFF_W-1:0] POFF_LIMIT = POFF_W'(PAIR_CAPACITY - 2);

  // record header layout
  localparam int REC_OFS_W = 17;
  localparam logic [REC_OFS_W-1:0] HDR_LEN      = 17'd8;
  localparam logic [REC_OFS_W-1:0] HDR_TYPE_OFS = 17'd1;
  localparam logic [REC_OFS_W-1:0] HDR_CLEN_HI  = 17'd4;
  localparam logic [REC_OFS_W-1:0] HDR_CLEN_LO  = 17'd5;
  localparam logic [REC_OFS_W-1:0] HDR_PAD_OFS  = 17'd6;
  localparam logic [7:0] REC_PARAMS = 8'd4;

  // name-value length encoding
  localparam int LEN_W = 31;
  localparam logic [7:0] LEN_LONG_BIT  = 8'h80;
  localparam logic [7:0] LEN_LONG_MASK = 8'h7F;
  localparam int LEN_LONG_BYTES = 4;

  // key being searched for
  localparam int KEY_LEN = 15;
  localparam logic [7:0] KEY_CHARS [KEY_LEN] = '{
    8'h53, 8'h43, 8'h52, 8'h49, 8'h50, 8'h54, 8'h5F, 8'h46,
    8'h49, 8'h4C, 8'h45, 8'h4E, 8'h41, 8'h4D, 8'h45
  };

  // queue between record tracker and pair parser
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_NAME_LEN,
    PH_VALUE_LEN,
    PH_PAIR
  } phase_e;

  // one classified stream byte
  typedef struct packed {
    logic [7:0] data;
    logic       param;
  } entry_t;

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (int'(idx) < KEY_LEN) begin
      ch = KEY_CHARS[idx];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== design/fsfe_front.sv =====
`default_nettype none

module fsfe_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      byte_i,
  output fsfe_pkg::entry_t     entry_o
);

  logic [fsfe_pkg::REC_OFS_W-1:0] off_q, off_d, off_eff, rec_end, content_end;
  logic [7:0]  type_q, type_d;
  logic [15:0] clen_q, clen_d;
  logic [7:0]  plen_q, plen_d;

  // record boundaries
  assign content_end = fsfe_pkg::HDR_LEN + fsfe_pkg::REC_OFS_W'(clen_q);
  assign rec_end     = content_end + fsfe_pkg::REC_OFS_W'(plen_q);
  assign off_eff     = (off_q >= fsfe_pkg::HDR_LEN && off_q >= rec_end) ? '0 : off_q;

  // classify the byte: only params content is marked for the pair parser
  assign entry_o.data  = byte_i;
  assign entry_o.param = (off_eff >= fsfe_pkg::HDR_LEN) &&
                         (type_q == fsfe_pkg::REC_PARAMS) &&
                         (off_eff < content_end);

  // header capture and offset advance
  always_comb begin
    off_d  = off_q;
    type_d = type_q;
    clen_d = clen_q;
    plen_d = plen_q;
    if (accept_i) begin
      off_d = off_eff + 1'b1;
      if (off_eff == fsfe_pkg::HDR_TYPE_OFS) begin
        type_d = byte_i;
      end
      if (off_eff == fsfe_pkg::HDR_CLEN_HI) begin
        clen_d = {byte_i, 8'h00};
      end
      if (off_eff == fsfe_pkg::HDR_CLEN_LO) begin
        clen_d = {clen_q[15:8], byte_i};
      end
      if (off_eff == fsfe_pkg::HDR_PAD_OFS) begin
        plen_d = byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q  <= '0;
      type_q <= '0;
      clen_q <= '0;
      plen_q <= '0;
    end else begin
      off_q  <= off_d;
      type_q <= type_d;
      clen_q <= clen_d;
      plen_q <= plen_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/fsfe_queue.sv =====
`default_nettype none

module fsfe_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire fsfe_pkg::entry_t entry_i,
  input  wire logic             pop_i,
  output fsfe_pkg::entry_t      entry_o,
  output logic                  not_empty_o,
  output logic                  full_o
);

  fsfe_pkg::entry_t mem_q [fsfe_pkg::QUEUE_DEPTH];
  logic [fsfe_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [fsfe_pkg::QCNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o      = (cnt_q == fsfe_pkg::QCNT_W'(fsfe_pkg::QUEUE_DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign entry_o     = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == fsfe_pkg::QPTR_W'(fsfe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == fsfe_pkg::QPTR_W'(fsfe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/fsfe_back.sv =====
`default_nettype none

module fsfe_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fsfe_pkg::entry_t entry_i,
  input  wire logic             avail_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            value_byte_o,
  output logic                  value_valid_o,
  output logic                  value_last_o,
  output logic                  filename_found_o,
  output logic                  overflow_o
);

  fsfe_pkg::phase_e phase_q, phase_d;
  logic [fsfe_pkg::POFF_W-1:0] poff_q, poff_d;
  logic [fsfe_pkg::LEN_W-1:0]  nlen_q, nlen_d, len_w;
  logic [fsfe_pkg::LEN_W:0]    total_q, total_d, total_w, poff_next;
  logic match_q, match_d, found_q, found_d, ovf_q, ovf_d;
  logic [7:0] lbytes_q [3];
  logic [7:0] c, byte0;
  logic [6:0] lb0_low;
  logic lb_we, short_form, long_form, work;
  logic [7:0] res_byte;
  logic res_valid, res_last;
  logic out_valid_q;
  logic [7:0] out_byte_q;
  logic out_vv_q, out_last_q, out_found_q, out_ovf_q;

  assign c      = entry_i.data;
  assign pop_o  = avail_i && (!out_valid_q || !out_stall_i);
  assign work   = pop_o && entry_i.param && !found_q && !ovf_q;

  // length decode: short form ends at the first byte, long form at the fourth
  assign byte0      = (poff_q == '0) ? c : lbytes_q[0];
  assign lb0_low    = 7'(lbytes_q[0] & fsfe_pkg::LEN_LONG_MASK);
  assign short_form = (poff_q == '0) && ((c & fsfe_pkg::LEN_LONG_BIT) == 8'h00);
  assign long_form  = (poff_q == fsfe_pkg::POFF_W'(fsfe_pkg::LEN_LONG_BYTES - 1)) &&
                      ((byte0 & fsfe_pkg::LEN_LONG_BIT) != 8'h00);
  assign len_w      = long_form ?
                      {lb0_low, lbytes_q[1], lbytes_q[2], c} :
                      fsfe_pkg::LEN_W'(c);
  assign total_w    = (fsfe_pkg::LEN_W + 1)'(nlen_q) + (fsfe_pkg::LEN_W + 1)'(len_w);
  assign poff_next  = (fsfe_pkg::LEN_W + 1)'(poff_q) + 1'b1;

  // pair parser
  always_comb begin
    phase_d   = phase_q;
    poff_d    = poff_q;
    nlen_d    = nlen_q;
    total_d   = total_q;
    match_d   = match_q;
    found_d   = found_q;
    ovf_d     = ovf_q;
    lb_we     = 1'b0;
    res_byte  = 8'h00;
    res_valid = 1'b0;
    res_last  = 1'b0;
    if (work) begin
      unique case (phase_q)
        fsfe_pkg::PH_NAME_LEN, fsfe_pkg::PH_VALUE_LEN: begin
          lb_we = (poff_q < fsfe_pkg::POFF_W'(3));
          if (short_form || long_form) begin
            poff_d = '0;
            if (phase_q == fsfe_pkg::PH_NAME_LEN) begin
              nlen_d  = len_w;
              phase_d = fsfe_pkg::PH_VALUE_LEN;
            end else begin
              total_d = total_w;
              match_d = (nlen_q == fsfe_pkg::LEN_W'(fsfe_pkg::KEY_LEN));
              phase_d = fsfe_pkg::PH_PAIR;
              // empty pair completes right here, never a match
              if (total_w == '0) begin
                phase_d = fsfe_pkg::PH_NAME_LEN;
                match_d = 1'b1;
              end
            end
          end else begin
            poff_d = poff_q + 1'b1;
          end
        end
        fsfe_pkg::PH_PAIR: begin
          if (poff_q >= fsfe_pkg::POFF_LIMIT) begin
            ovf_d = 1'b1;
          end else begin
            if (fsfe_pkg::LEN_W'(poff_q) < nlen_q) begin
              if (poff_q >= fsfe_pkg::POFF_W'(fsfe_pkg::KEY_LEN) ||
                  c != fsfe_pkg::key_char(poff_q[3:0])) begin
                match_d = 1'b0;
              end
            end else if (match_q && nlen_q == fsfe_pkg::LEN_W'(fsfe_pkg::KEY_LEN)) begin
              res_byte  = c;
              res_valid = 1'b1;
            end
            poff_d = poff_q + 1'b1;
            // pair complete
            if (poff_next >= total_q) begin
              if (match_d && nlen_q == fsfe_pkg::LEN_W'(fsfe_pkg::KEY_LEN)) begin
                found_d  = 1'b1;
                res_last = 1'b1;
              end
              phase_d = fsfe_pkg::PH_NAME_LEN;
              poff_d  = '0;
              match_d = 1'b1;
            end
          end
        end
        default: begin
          phase_d = fsfe_pkg::PH_NAME_LEN;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fsfe_pkg::PH_NAME_LEN;
      poff_q  <= '0;
      nlen_q  <= '0;
      total_q <= '0;
      match_q <= 1'b1;
      found_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      poff_q  <= poff_d;
      nlen_q  <= nlen_d;
      total_q <= total_d;
      match_q <= match_d;
      found_q <= found_d;
      ovf_q   <= ovf_d;
    end
  end

  // length bytes, always written before they are read
  always_ff @(posedge clk_i) begin
    if (lb_we) begin
      lbytes_q[poff_q[1:0]] <= c;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= avail_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_byte_q  <= res_byte;
      out_vv_q    <= res_valid;
      out_last_q  <= res_last;
      out_found_q <= found_d;
      out_ovf_q   <= ovf_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign value_byte_o     = out_byte_q;
  assign value_valid_o    = out_vv_q;
  assign value_last_o     = out_last_q;
  assign filename_found_o = out_found_q;
  assign overflow_o       = out_ovf_q;

endmodule

`default_nettype wire

// ===== design/fastcgi_script_filename_extractor.sv =====
// channel | valid      | stall      | payload
// --------+------------+------------+----------------------------------------------
// in      | in_valid_i | in_stall_o | in_byte_i
// out     | out_valid_o| out_stall_i| value_byte_o value_valid_o value_last_o
//         |            |            | filename_found_o overflow_o
//
// one byte per cycle sustained while the output is not stalled; each beat in gives exactly one beat out
// a byte that is taken is written to the two-entry queue, then the pair parser pops it
// and loads the output register
// reset is asynchronous, active low, and clears all tracking and sticky flags
// in_stall_o rises only when the two-entry queue is full behind a stalled output
`default_nettype none

module fastcgi_script_filename_extractor (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      value_byte_o,
  output logic            value_valid_o,
  output logic            value_last_o,
  output logic            filename_found_o,
  output logic            overflow_o
);

  fsfe_pkg::entry_t front_entry, back_entry;
  logic q_full, q_avail, q_pop, in_take;

  assign in_stall_o = q_full;
  assign in_take    = in_valid_i && !q_full;

  // record tracker
  fsfe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_take),
    .byte_i   (in_byte_i),
    .entry_o  (front_entry)
  );

  // decoupling queue
  fsfe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_take),
    .entry_i     (front_entry),
    .pop_i       (q_pop),
    .entry_o     (back_entry),
    .not_empty_o (q_avail),
    .full_o      (q_full)
  );

  // name-value parser and output register
  fsfe_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .entry_i          (back_entry),
    .avail_i          (q_avail),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .value_byte_o     (value_byte_o),
    .value_valid_o    (value_valid_o),
    .value_last_o     (value_last_o),
    .filename_found_o (filename_found_o),
    .overflow_o       (overflow_o)
  );

endmodule

`default_nettype wire

// ===== design/fsfe_checker.sv =====
`default_nettype none
`include "fastcgi_script_filename_extractor_macros.svh"

module fsfe_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] value_byte_o,
  input wire logic       value_valid_o,
  input wire logic       value_last_o,
  input wire logic       filename_found_o,
  input wire logic       overflow_o
);

  // completion of the filename always raises the found flag
  `FSFE_ASSERT(a_last_sets_found, clk_i,
    (out_valid_o && value_last_o |-> filename_found_o), "last beat without found flag")

  // after the filename is complete no further value bytes come out
  `FSFE_ASSERT_RST(a_no_byte_after_found, clk_i, rst_ni,
    (out_valid_o && filename_found_o && !value_last_o |-> !value_valid_o),
    "value byte after filename found")

  // found flag is sticky across beats
  `FSFE_ASSERT_RST(a_found_sticky, clk_i, rst_ni,
    (out_valid_o && !out_stall_i && filename_found_o ##1 out_valid_o |-> filename_found_o),
    "found flag dropped")

  // overflow flag is sticky across beats
  `FSFE_ASSERT_RST(a_overflow_sticky, clk_i, rst_ni,
    (out_valid_o && !out_stall_i && overflow_o ##1 out_valid_o |-> overflow_o),
    "overflow flag dropped")

  // a stalled output beat holds
  `FSFE_ASSERT_RST(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i |=> out_valid_o && $stable(value_byte_o) &&
     $stable(value_last_o)), "stalled output beat changed")

endmodule

bind fastcgi_script_filename_extractor fsfe_checker u_fsfe_checker (.*);

`default_nettype wire
